/* rtl/kalman_filter_2d_position_defines.svh */
// Assertion macros shared by the checker of the 2-D position Kalman filter.
// Depends on nothing; the including module must provide clock and reset.
`ifndef KALMAN_FILTER_2D_POSITION_DEFINES_SVH
`define KALMAN_FILTER_2D_POSITION_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define KF2D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define KF2D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define KF2D_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/kf2d_pkg.sv */
// Shared types and constants of the 2-D position Kalman filter.
// Depends on nothing; used by kf2d_datapath, kf2d_ctrl, the top level and the checker.
package kf2d_pkg;

   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_ERROR     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_X         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_Y         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_TIME         = 3'd5;

   localparam logic [30:0] PROCESS_NOISE_RESET     = 31'd6554;
   localparam logic [30:0] MEASUREMENT_NOISE_RESET = 31'd6554;
   localparam logic [30:0] INITIAL_ERROR_RESET     = 31'd65536;
   localparam logic [15:0] STEP_TIME_RESET         = 16'd6554;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] estimate_x;
      logic signed [31:0] estimate_y;
      logic signed [31:0] variance_x;
      logic signed [31:0] variance_y;
      logic              singular;
   } rsp_type;

   // Names of the datapath registers that the sequencer addresses.
   typedef enum logic [4:0] {
      R_ZERO, R_T, R_U, R_S00, R_S11, R_A01, R_A10, R_DET,
      R_K0, R_K1, R_K2, R_K3, R_Y0, R_Y1, R_POS0, R_POS1,
      R_P0, R_P1, R_P2, R_P3, R_N0, R_N1, R_N2, R_N3,
      R_V0, R_V1, R_PN, R_RN, R_STEP
   } reg_name_type;

   typedef struct packed {
      logic         load;
      logic         alu_en;
      logic         alu_sub;
      logic         mul_start;
      logic         mul_step;
      logic         mul_wr;
      logic         div_start;
      logic         div_wr;
      logic         commit;
      logic         set_singular;
      logic         out_load;
      reg_name_type src_a;
      reg_name_type src_b;
      reg_name_type dst;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic det_zero;
   } status_type;

endpackage

/* rtl/kf2d_mul.sv */
// Sequential signed multiplier with truncating shift and saturation.
// Depends on nothing beyond its parameters; used by kf2d_datapath.
module kf2d_mul #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                shift16,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic                done,
   output logic signed [W-1:0] result
);

   localparam int NCH = (W + 15) / 16;
   localparam int BW  = NCH * 16;
   localparam int AW  = W + BW;
   localparam int CW  = $clog2(NCH + 1);

   logic [W-1:0]  ua_ff;
   logic [BW-1:0] b_ff;
   logic [AW-1:0] acc_ff;
   logic          neg_ff;
   logic          sh16_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          fin_ff;
   logic          done_ff;
   logic signed [W-1:0] res_ff;

   logic [W-1:0]    ua_in;
   logic [W-1:0]    ub_in;
   logic [W+15:0]   partial;
   logic [AW-1:0]   acc_in;
   logic [AW-1:0]   shifted;
   logic [AW-1:0]   limit;
   logic [AW-1:0]   mag_sat;
   logic [W-1:0]    mag_w;

   assign ua_in   = a[W-1] ? (~a + W'(1)) : a;
   assign ub_in   = b[W-1] ? (~b + W'(1)) : b;
   assign partial = ua_ff * b_ff[BW-1 -: 16];
   assign acc_in  = (acc_ff << 16) + AW'(partial);
   assign shifted = sh16_ff ? (acc_ff >> 16) : (acc_ff >> F);
   assign limit   = AW'({(W-1){1'b1}}) + AW'(neg_ff);
   assign mag_sat = (shifted > limit) ? limit : shifted;
   assign mag_w   = mag_sat[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fin_ff  <= 1'b0;
         end else if (busy_ff && cnt_ff == CW'(NCH - 1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff   <= ua_in;
         b_ff    <= BW'(ub_in);
         acc_ff  <= '0;
         neg_ff  <= a[W-1] ^ b[W-1];
         sh16_ff <= shift16;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff << 16;
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (fin_ff) begin
         res_ff <= neg_ff ? -$signed(mag_w) : $signed(mag_w);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* rtl/kf2d_div.sv */
// Restoring divider giving (n << F) / d, truncated toward zero and saturated.
// Depends on nothing beyond its parameters; used by kf2d_datapath.
module kf2d_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] n,
   input  logic signed [W-1:0] d,
   output logic                done,
   output logic signed [W-1:0] result
);

   localparam int NW = W + F;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff;
   logic [NW-1:0] q_ff;
   logic [W-1:0]  ud_ff;
   logic [W:0]    rem_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          fin_ff;
   logic          done_ff;
   logic signed [W-1:0] res_ff;

   logic [W-1:0]  un_in;
   logic [W-1:0]  ud_in;
   logic [W:0]    trial;
   logic          fits;
   logic [NW-1:0] limit;
   logic [NW-1:0] q_sat;
   logic [W-1:0]  q_w;

   assign un_in = n[W-1] ? (~n + W'(1)) : n;
   assign ud_in = d[W-1] ? (~d + W'(1)) : d;
   assign trial = {rem_ff[W-1:0], num_ff[NW-1]};
   assign fits  = (trial >= {1'b0, ud_ff});
   assign limit = NW'({(W-1){1'b1}}) + NW'(neg_ff);
   assign q_sat = (q_ff > limit) ? limit : q_ff;
   assign q_w   = q_sat[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fin_ff  <= 1'b0;
         end else if (busy_ff && cnt_ff == CW'(NW - 1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {un_in, {F{1'b0}}};
         ud_ff  <= ud_in;
         rem_ff <= '0;
         q_ff   <= '0;
         neg_ff <= n[W-1] ^ d[W-1];
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, ud_ff}) : trial;
         q_ff   <= {q_ff[NW-2:0], fits};
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (fin_ff) begin
         res_ff <= neg_ff ? -$signed(q_w) : $signed(q_w);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* rtl/kf2d_datapath.sv */
// Datapath of the 2-D position Kalman filter: state, configuration, ALU,
// multiplier, divider and result register. Depends on kf2d_pkg, kf2d_mul, kf2d_div.
module kf2d_datapath #(
   parameter int W = kf2d_pkg::WORD_WIDTH_DEFAULT,
   parameter int F = kf2d_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  kf2d_pkg::cmd_type                        cmd,
   output kf2d_pkg::status_type                     status,
   input  kf2d_pkg::req_type                        req_data,
   input  logic                                     csr_write_enable,
   input  logic [kf2d_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [kf2d_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   output kf2d_pkg::rsp_type                        rsp_data
);

   localparam int EW = ((W > 32) ? W : 32) + 1;
   localparam logic signed [EW-1:0] WMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
   localparam logic signed [EW-1:0] OMAX_E = {{(EW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [EW-1:0] OMIN_E = ~OMAX_E;

   function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
      logic signed [W-1:0] r;
      if (v > WMAX_E)      r = WMAX_E[W-1:0];
      else if (v < WMIN_E) r = WMIN_E[W-1:0];
      else                 r = v[W-1:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat_out(input logic signed [W-1:0] v);
      logic signed [EW-1:0] e;
      logic signed [31:0]   r;
      e = EW'(v);
      if (e > OMAX_E)      r = OMAX_E[31:0];
      else if (e < OMIN_E) r = OMIN_E[31:0];
      else                 r = e[31:0];
      return r;
   endfunction

   // Configuration registers.
   logic signed [W-1:0] pn_ff, rn_ff, init_err_ff, init_x_ff, init_y_ff;
   logic [15:0]         step_ff;
   // Filter state.
   logic signed [W-1:0] pos0_ff, pos1_ff, p0_ff, p1_ff, p2_ff, p3_ff;
   // Working registers.
   logic signed [W-1:0] t_ff, u_ff, s00_ff, s11_ff, a01_ff, a10_ff, det_ff;
   logic signed [W-1:0] k0_ff, k1_ff, k2_ff, k3_ff, y0_ff, y1_ff;
   logic signed [W-1:0] n0_ff, n1_ff, n2_ff, n3_ff, v0_ff, v1_ff;
   logic                sing_ff;
   kf2d_pkg::rsp_type   rsp_ff;

   logic signed [W-1:0] init_err_in, init_x_in, init_y_in;
   logic                reseed;
   logic signed [W-1:0] opa, opb, alu_res, mul_res, div_res, wr_data;
   logic signed [EW-1:0] alu_sum;
   logic                wr_en, mul_done, div_done;

   function automatic logic signed [W-1:0] operand(input kf2d_pkg::reg_name_type r,
         input logic signed [W-1:0] t, u, s00, s11, a01, a10, det, k0, k1, k2, k3,
         input logic signed [W-1:0] y0, y1, ps0, ps1, p0, p1, p2, p3,
         input logic signed [W-1:0] v0, v1, pn, rn, st);
      logic signed [W-1:0] o;
      case (r)
         kf2d_pkg::R_T:    o = t;
         kf2d_pkg::R_U:    o = u;
         kf2d_pkg::R_S00:  o = s00;
         kf2d_pkg::R_S11:  o = s11;
         kf2d_pkg::R_A01:  o = a01;
         kf2d_pkg::R_A10:  o = a10;
         kf2d_pkg::R_DET:  o = det;
         kf2d_pkg::R_K0:   o = k0;
         kf2d_pkg::R_K1:   o = k1;
         kf2d_pkg::R_K2:   o = k2;
         kf2d_pkg::R_K3:   o = k3;
         kf2d_pkg::R_Y0:   o = y0;
         kf2d_pkg::R_Y1:   o = y1;
         kf2d_pkg::R_POS0: o = ps0;
         kf2d_pkg::R_POS1: o = ps1;
         kf2d_pkg::R_P0:   o = p0;
         kf2d_pkg::R_P1:   o = p1;
         kf2d_pkg::R_P2:   o = p2;
         kf2d_pkg::R_P3:   o = p3;
         kf2d_pkg::R_V0:   o = v0;
         kf2d_pkg::R_V1:   o = v1;
         kf2d_pkg::R_PN:   o = pn;
         kf2d_pkg::R_RN:   o = rn;
         kf2d_pkg::R_STEP: o = st;
         default:          o = '0;
      endcase
      return o;
   endfunction

   logic signed [W-1:0] step_w;
   assign step_w = $signed({{(W-16){1'b0}}, step_ff});

   assign opa = operand(cmd.src_a, t_ff, u_ff, s00_ff, s11_ff, a01_ff, a10_ff, det_ff,
                        k0_ff, k1_ff, k2_ff, k3_ff, y0_ff, y1_ff, pos0_ff, pos1_ff,
                        p0_ff, p1_ff, p2_ff, p3_ff, v0_ff, v1_ff, pn_ff, rn_ff, step_w);
   assign opb = operand(cmd.src_b, t_ff, u_ff, s00_ff, s11_ff, a01_ff, a10_ff, det_ff,
                        k0_ff, k1_ff, k2_ff, k3_ff, y0_ff, y1_ff, pos0_ff, pos1_ff,
                        p0_ff, p1_ff, p2_ff, p3_ff, v0_ff, v1_ff, pn_ff, rn_ff, step_w);

   assign alu_sum = cmd.alu_sub ? (EW'(opa) - EW'(opb)) : (EW'(opa) + EW'(opb));
   assign alu_res = sat_w(alu_sum);

   kf2d_mul #(.W(W), .F(F)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .shift16 (cmd.mul_step),
      .a       (opa),
      .b       (opb),
      .done    (mul_done),
      .result  (mul_res)
   );

   kf2d_div #(.W(W), .F(F)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .n      (opa),
      .d      (det_ff),
      .done   (div_done),
      .result (div_res)
   );

   assign wr_en   = cmd.alu_en | cmd.mul_wr | cmd.div_wr;
   assign wr_data = cmd.alu_en ? alu_res : (cmd.mul_wr ? mul_res : div_res);

   // New initial values take effect in the same cycle as the reseed.
   always_comb begin
      init_err_in = init_err_ff;
      init_x_in   = init_x_ff;
      init_y_in   = init_y_ff;
      reseed      = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            kf2d_pkg::CSR_INITIAL_ERROR: begin
               init_err_in = sat_w(EW'({1'b0, csr_data[30:0]}));
               reseed      = 1'b1;
            end
            kf2d_pkg::CSR_INITIAL_X: begin
               init_x_in = sat_w(EW'($signed(csr_data)));
               reseed    = 1'b1;
            end
            kf2d_pkg::CSR_INITIAL_Y: begin
               init_y_in = sat_w(EW'($signed(csr_data)));
               reseed    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff       <= sat_w(EW'({1'b0, kf2d_pkg::PROCESS_NOISE_RESET}));
         rn_ff       <= sat_w(EW'({1'b0, kf2d_pkg::MEASUREMENT_NOISE_RESET}));
         init_err_ff <= sat_w(EW'({1'b0, kf2d_pkg::INITIAL_ERROR_RESET}));
         init_x_ff   <= '0;
         init_y_ff   <= '0;
         step_ff     <= kf2d_pkg::STEP_TIME_RESET;
         pos0_ff     <= '0;
         pos1_ff     <= '0;
         p0_ff       <= sat_w(EW'({1'b0, kf2d_pkg::INITIAL_ERROR_RESET}));
         p1_ff       <= '0;
         p2_ff       <= '0;
         p3_ff       <= sat_w(EW'({1'b0, kf2d_pkg::INITIAL_ERROR_RESET}));
         sing_ff     <= 1'b0;
      end else begin
         init_err_ff <= init_err_in;
         init_x_ff   <= init_x_in;
         init_y_ff   <= init_y_in;
         if (csr_write_enable && csr_index == kf2d_pkg::CSR_PROCESS_NOISE) begin
            pn_ff <= sat_w(EW'({1'b0, csr_data[30:0]}));
         end
         if (csr_write_enable && csr_index == kf2d_pkg::CSR_MEASUREMENT_NOISE) begin
            rn_ff <= sat_w(EW'({1'b0, csr_data[30:0]}));
         end
         if (csr_write_enable && csr_index == kf2d_pkg::CSR_STEP_TIME) begin
            step_ff <= csr_data[15:0];
         end
         if (reseed) begin
            pos0_ff <= init_x_in;
            pos1_ff <= init_y_in;
            p0_ff   <= init_err_in;
            p1_ff   <= '0;
            p2_ff   <= '0;
            p3_ff   <= init_err_in;
         end else if (cmd.commit) begin
            p0_ff <= n0_ff;
            p1_ff <= n1_ff;
            p2_ff <= n2_ff;
            p3_ff <= n3_ff;
         end else if (wr_en) begin
            case (cmd.dst)
               kf2d_pkg::R_POS0: pos0_ff <= wr_data;
               kf2d_pkg::R_POS1: pos1_ff <= wr_data;
               kf2d_pkg::R_P0:   p0_ff   <= wr_data;
               kf2d_pkg::R_P3:   p3_ff   <= wr_data;
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            sing_ff <= 1'b0;
         end else if (cmd.set_singular) begin
            sing_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v0_ff <= sat_w(EW'(req_data.value_x));
         v1_ff <= sat_w(EW'(req_data.value_y));
      end
      if (wr_en) begin
         case (cmd.dst)
            kf2d_pkg::R_T:   t_ff   <= wr_data;
            kf2d_pkg::R_U:   u_ff   <= wr_data;
            kf2d_pkg::R_S00: s00_ff <= wr_data;
            kf2d_pkg::R_S11: s11_ff <= wr_data;
            kf2d_pkg::R_A01: a01_ff <= wr_data;
            kf2d_pkg::R_A10: a10_ff <= wr_data;
            kf2d_pkg::R_DET: det_ff <= wr_data;
            kf2d_pkg::R_K0:  k0_ff  <= wr_data;
            kf2d_pkg::R_K1:  k1_ff  <= wr_data;
            kf2d_pkg::R_K2:  k2_ff  <= wr_data;
            kf2d_pkg::R_K3:  k3_ff  <= wr_data;
            kf2d_pkg::R_Y0:  y0_ff  <= wr_data;
            kf2d_pkg::R_Y1:  y1_ff  <= wr_data;
            kf2d_pkg::R_N0:  n0_ff  <= wr_data;
            kf2d_pkg::R_N1:  n1_ff  <= wr_data;
            kf2d_pkg::R_N2:  n2_ff  <= wr_data;
            kf2d_pkg::R_N3:  n3_ff  <= wr_data;
            default: begin
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff.estimate_x <= sat_out(pos0_ff);
         rsp_ff.estimate_y <= sat_out(pos1_ff);
         rsp_ff.variance_x <= sat_out(p0_ff);
         rsp_ff.variance_y <= sat_out(p3_ff);
         rsp_ff.singular   <= sing_ff;
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.det_zero = (det_ff == '0);
   assign rsp_data        = rsp_ff;

endmodule

/* rtl/kf2d_ctrl.sv */
// Sequencer of the 2-D position Kalman filter: handshakes and micro-program.
// Depends on kf2d_pkg.
module kf2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kf2d_pkg::cmd_type    cmd,
   input  kf2d_pkg::status_type status
);

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT_MUL, S_WAIT_DIV, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      I_ADD, I_SUB, I_MUL, I_MULS, I_DIV, I_BRZ, I_COMMIT, I_END
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      kf2d_pkg::reg_name_type a;
      kf2d_pkg::reg_name_type b;
      kf2d_pkg::reg_name_type d;
   } instr_type;

   localparam logic [5:0] PC_PREDICT = 6'd0;
   localparam logic [5:0] PC_UPDATE  = 6'd7;

   function automatic instr_type mk(input kind_type k, input kf2d_pkg::reg_name_type a,
                                    input kf2d_pkg::reg_name_type b,
                                    input kf2d_pkg::reg_name_type d);
      instr_type i;
      i.kind = k;
      i.a    = a;
      i.b    = b;
      i.d    = d;
      return i;
   endfunction

   function automatic instr_type program_rom(input logic [5:0] pc);
      instr_type i;
      unique case (pc)
         // Predict: position += velocity * step, diagonal += process noise.
         6'd0:  i = mk(I_MULS, kf2d_pkg::R_V0, kf2d_pkg::R_STEP, kf2d_pkg::R_T);
         6'd1:  i = mk(I_ADD, kf2d_pkg::R_POS0, kf2d_pkg::R_T, kf2d_pkg::R_POS0);
         6'd2:  i = mk(I_MULS, kf2d_pkg::R_V1, kf2d_pkg::R_STEP, kf2d_pkg::R_T);
         6'd3:  i = mk(I_ADD, kf2d_pkg::R_POS1, kf2d_pkg::R_T, kf2d_pkg::R_POS1);
         6'd4:  i = mk(I_ADD, kf2d_pkg::R_P0, kf2d_pkg::R_PN, kf2d_pkg::R_P0);
         6'd5:  i = mk(I_ADD, kf2d_pkg::R_P3, kf2d_pkg::R_PN, kf2d_pkg::R_P3);
         6'd6:  i = mk(I_END, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO);
         // Update: residual covariance, its determinant and adjugate.
         6'd7:  i = mk(I_ADD, kf2d_pkg::R_P0, kf2d_pkg::R_RN, kf2d_pkg::R_S00);
         6'd8:  i = mk(I_ADD, kf2d_pkg::R_P3, kf2d_pkg::R_RN, kf2d_pkg::R_S11);
         6'd9:  i = mk(I_SUB, kf2d_pkg::R_ZERO, kf2d_pkg::R_P1, kf2d_pkg::R_A01);
         6'd10: i = mk(I_SUB, kf2d_pkg::R_ZERO, kf2d_pkg::R_P2, kf2d_pkg::R_A10);
         6'd11: i = mk(I_MUL, kf2d_pkg::R_S00, kf2d_pkg::R_S11, kf2d_pkg::R_T);
         6'd12: i = mk(I_MUL, kf2d_pkg::R_P1, kf2d_pkg::R_P2, kf2d_pkg::R_U);
         6'd13: i = mk(I_SUB, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_DET);
         6'd14: i = mk(I_BRZ, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO);
         // Gain entries.
         6'd15: i = mk(I_MUL, kf2d_pkg::R_P0, kf2d_pkg::R_S11, kf2d_pkg::R_T);
         6'd16: i = mk(I_MUL, kf2d_pkg::R_P1, kf2d_pkg::R_A10, kf2d_pkg::R_U);
         6'd17: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd18: i = mk(I_DIV, kf2d_pkg::R_T, kf2d_pkg::R_ZERO, kf2d_pkg::R_K0);
         6'd19: i = mk(I_MUL, kf2d_pkg::R_P0, kf2d_pkg::R_A01, kf2d_pkg::R_T);
         6'd20: i = mk(I_MUL, kf2d_pkg::R_P1, kf2d_pkg::R_S00, kf2d_pkg::R_U);
         6'd21: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd22: i = mk(I_DIV, kf2d_pkg::R_T, kf2d_pkg::R_ZERO, kf2d_pkg::R_K1);
         6'd23: i = mk(I_MUL, kf2d_pkg::R_P2, kf2d_pkg::R_S11, kf2d_pkg::R_T);
         6'd24: i = mk(I_MUL, kf2d_pkg::R_P3, kf2d_pkg::R_A10, kf2d_pkg::R_U);
         6'd25: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd26: i = mk(I_DIV, kf2d_pkg::R_T, kf2d_pkg::R_ZERO, kf2d_pkg::R_K2);
         6'd27: i = mk(I_MUL, kf2d_pkg::R_P2, kf2d_pkg::R_A01, kf2d_pkg::R_T);
         6'd28: i = mk(I_MUL, kf2d_pkg::R_P3, kf2d_pkg::R_S00, kf2d_pkg::R_U);
         6'd29: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd30: i = mk(I_DIV, kf2d_pkg::R_T, kf2d_pkg::R_ZERO, kf2d_pkg::R_K3);
         // Innovation and position correction.
         6'd31: i = mk(I_SUB, kf2d_pkg::R_V0, kf2d_pkg::R_POS0, kf2d_pkg::R_Y0);
         6'd32: i = mk(I_SUB, kf2d_pkg::R_V1, kf2d_pkg::R_POS1, kf2d_pkg::R_Y1);
         6'd33: i = mk(I_MUL, kf2d_pkg::R_K0, kf2d_pkg::R_Y0, kf2d_pkg::R_T);
         6'd34: i = mk(I_MUL, kf2d_pkg::R_K1, kf2d_pkg::R_Y1, kf2d_pkg::R_U);
         6'd35: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd36: i = mk(I_ADD, kf2d_pkg::R_POS0, kf2d_pkg::R_T, kf2d_pkg::R_POS0);
         6'd37: i = mk(I_MUL, kf2d_pkg::R_K2, kf2d_pkg::R_Y0, kf2d_pkg::R_T);
         6'd38: i = mk(I_MUL, kf2d_pkg::R_K3, kf2d_pkg::R_Y1, kf2d_pkg::R_U);
         6'd39: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd40: i = mk(I_ADD, kf2d_pkg::R_POS1, kf2d_pkg::R_T, kf2d_pkg::R_POS1);
         // Covariance correction into the shadow registers, then commit.
         6'd41: i = mk(I_MUL, kf2d_pkg::R_K0, kf2d_pkg::R_P0, kf2d_pkg::R_T);
         6'd42: i = mk(I_MUL, kf2d_pkg::R_K1, kf2d_pkg::R_P2, kf2d_pkg::R_U);
         6'd43: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd44: i = mk(I_SUB, kf2d_pkg::R_P0, kf2d_pkg::R_T, kf2d_pkg::R_N0);
         6'd45: i = mk(I_MUL, kf2d_pkg::R_K0, kf2d_pkg::R_P1, kf2d_pkg::R_T);
         6'd46: i = mk(I_MUL, kf2d_pkg::R_K1, kf2d_pkg::R_P3, kf2d_pkg::R_U);
         6'd47: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd48: i = mk(I_SUB, kf2d_pkg::R_P1, kf2d_pkg::R_T, kf2d_pkg::R_N1);
         6'd49: i = mk(I_MUL, kf2d_pkg::R_K2, kf2d_pkg::R_P0, kf2d_pkg::R_T);
         6'd50: i = mk(I_MUL, kf2d_pkg::R_K3, kf2d_pkg::R_P2, kf2d_pkg::R_U);
         6'd51: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd52: i = mk(I_SUB, kf2d_pkg::R_P2, kf2d_pkg::R_T, kf2d_pkg::R_N2);
         6'd53: i = mk(I_MUL, kf2d_pkg::R_K2, kf2d_pkg::R_P1, kf2d_pkg::R_T);
         6'd54: i = mk(I_MUL, kf2d_pkg::R_K3, kf2d_pkg::R_P3, kf2d_pkg::R_U);
         6'd55: i = mk(I_ADD, kf2d_pkg::R_T, kf2d_pkg::R_U, kf2d_pkg::R_T);
         6'd56: i = mk(I_SUB, kf2d_pkg::R_P3, kf2d_pkg::R_T, kf2d_pkg::R_N3);
         6'd57: i = mk(I_COMMIT, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO);
         default: i = mk(I_END, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO, kf2d_pkg::R_ZERO);
      endcase
      return i;
   endfunction

   state_type  state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   instr_type  instr;

   always_comb begin
      instr          = program_rom(pc_ff);
      state_in       = state_ff;
      pc_in          = pc_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.src_a      = instr.a;
      cmd.src_b      = instr.b;
      cmd.dst        = instr.d;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = (req_operation == kf2d_pkg::OP_UPDATE) ? PC_UPDATE : PC_PREDICT;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            unique case (instr.kind)
               I_ADD, I_SUB: begin
                  cmd.alu_en  = 1'b1;
                  cmd.alu_sub = (instr.kind == I_SUB);
                  pc_in       = pc_ff + 6'd1;
               end
               I_MUL, I_MULS: begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_step  = (instr.kind == I_MULS);
                  state_in      = S_WAIT_MUL;
               end
               I_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_WAIT_DIV;
               end
               I_BRZ: begin
                  if (status.det_zero) begin
                     cmd.set_singular = 1'b1;
                     state_in         = S_FINISH;
                  end else begin
                     pc_in = pc_ff + 6'd1;
                  end
               end
               I_COMMIT: begin
                  cmd.commit = 1'b1;
                  pc_in      = pc_ff + 6'd1;
               end
               I_END: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WAIT_MUL: begin
            if (status.mul_done) begin
               cmd.mul_wr = 1'b1;
               pc_in      = pc_ff + 6'd1;
               state_in   = S_ISSUE;
            end
         end
         S_WAIT_DIV: begin
            if (status.div_done) begin
               cmd.div_wr = 1'b1;
               pc_in      = pc_ff + 6'd1;
               state_in   = S_ISSUE;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= PC_PREDICT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/kalman_filter_2d_position.sv */
// Top level of the 2-D position Kalman filter in signed fixed point.
// Depends on kf2d_pkg, kf2d_ctrl and kf2d_datapath.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_data (operation, value_x, value_y)
//   rsp_      out        rsp_valid/rsp_ready  rsp_data (estimates, variances, singular)
//   csr_      in         csr_write_enable     csr_index, csr_data
//
// One item is worked on at a time by a micro-programmed sequencer driving one shared
// multiplier and one shared divider. Each multiply or divide is issued, run until done
// and written back before the next step; a division gives one quotient bit per cycle.
// The four gain divisions take up most of an update, and an update that finds a zero
// determinant stops at that check and returns its result with the singular flag set.
// Reset is synchronous and active high; it restores the register defaults and seeds
// the state from them. A finished result waits in the output register, so the next
// transfer is accepted while it is stalled; a further result then waits for it.
module kalman_filter_2d_position #(
   parameter int FRAC_BITS  = kf2d_pkg::FRAC_BITS_DEFAULT,
   parameter int WORD_WIDTH = kf2d_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  kf2d_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output kf2d_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [kf2d_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kf2d_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   // Commands from the sequencer and the flags it branches and waits on.
   kf2d_pkg::cmd_type    cmd;
   kf2d_pkg::status_type status;

   kf2d_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   // Configuration writes go to the datapath unchecked; make them only while idle.
   kf2d_datapath #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_data         (rsp_data)
   );

endmodule

/* rtl/kf2d_checker.sv */
// Port-level checker of the 2-D position Kalman filter, bound to the top level.
// Depends on kf2d_pkg and kalman_filter_2d_position_defines.svh.
`include "kalman_filter_2d_position_defines.svh"

module kf2d_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kf2d_pkg::rsp_type rsp_data
);

   `KF2D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `KF2D_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second transfer accepted while busy")
   `KF2D_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "result appeared one cycle after a transfer")
   `KF2D_ASSERT_NEXT_ALWAYS(a_reset_state, reset, !rsp_valid && req_ready, "reset did not clear the handshakes")

endmodule

bind kalman_filter_2d_position kf2d_checker u_kf2d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
